// ===== rtl/cone_mesh_vertex_generator_top_assert.svh =====
// Assertion macros for the cone mesh vertex generator.
`ifndef CONE_MESH_VERTEX_GENERATOR_TOP_ASSERT_SVH
`define CONE_MESH_VERTEX_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define CMVG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CMVG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CMVG_ASSERT_IMP(lbl, ante, cons)
`define CMVG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/cmvg_pkg.sv =====
`timescale 1ns / 1ps
package cmvg_pkg;

  localparam int CoordW  = 32;
  localparam int QuatW   = 16;
  localparam int ScaleW  = 16;
  localparam int DimW    = 14;
  localparam int CntW    = 7;
  localparam int IdxW    = 6;
  localparam int TexW    = 17;
  localparam int CornerW = 3;
  localparam int LenW    = DimW + ScaleW;
  localparam int RecipW  = 32;

  localparam logic [TexW-1:0] TexHalf = 17'd32768;
  localparam logic [TexW-1:0] TexOne  = 17'd65536;

  localparam int SinA = 25736;
  localparam int SinB = 10512;
  localparam int SinC = 1160;

  localparam logic [1:0] RegRadius = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegCount  = 2'd2;

  typedef enum logic [1:0] {
    KindRing   = 2'd0,
    KindApex   = 2'd1,
    KindCenter = 2'd2
  } kind_e;

  typedef enum logic [CornerW-1:0] {
    CrnRing0   = 3'd0,
    CrnRing1   = 3'd1,
    CrnApex    = 3'd2,
    CrnCenter  = 3'd3,
    CrnRing1b  = 3'd4,
    CrnRing0b  = 3'd5
  } corner_e;

  typedef struct packed {
    kind_e                    kind;
    corner_e                  corner;
    logic signed [CoordW-1:0] base_x;
    logic signed [CoordW-1:0] base_y;
    logic signed [CoordW-1:0] base_z;
    logic signed [QuatW-1:0]  quat_x;
    logic signed [QuatW-1:0]  quat_y;
    logic signed [QuatW-1:0]  quat_z;
    logic signed [QuatW-1:0]  quat_w;
    logic [LenW-1:0]          len_r;
    logic [LenW-1:0]          len_h;
    logic [TexW-1:0]          tex_u;
    logic [TexW-1:0]          tex_v;
  } vtx_t;

endpackage

// ===== rtl/cmvg_regs.sv =====
`timescale 1ns / 1ps
module cmvg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [cmvg_pkg::DimW-1:0] radius_o,
  output logic [cmvg_pkg::DimW-1:0] height_o,
  output logic [cmvg_pkg::CntW-1:0] count_o
);
  import cmvg_pkg::*;

  logic [DimW-1:0] radius_q, height_q;
  logic [CntW-1:0] count_q;
  logic            wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 14'd256;
      height_q <= 14'd256;
      count_q  <= 7'd16;
    end else if (wr) begin
      unique case (paddr[3:2])
        RegRadius: radius_q <= pwdata[DimW-1:0];
        RegHeight: height_q <= pwdata[DimW-1:0];
        RegCount:  count_q  <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegRadius: prdata = 32'(radius_q);
      RegHeight: prdata = 32'(height_q);
      RegCount:  prdata = 32'(count_q);
      default:   prdata = 32'd0;
    endcase
  end

  assign radius_o = radius_q;
  assign height_o = height_q;
  assign count_o  = count_q;
endmodule

// ===== rtl/cmvg_seq.sv =====
`timescale 1ns / 1ps
module cmvg_seq #(
  parameter int MAX_SEGMENTS = 64,
  parameter int KW = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_valid_i,
  output logic                             s_ready_o,
  input  logic signed [cmvg_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [cmvg_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [cmvg_pkg::CoordW-1:0] pos_z_i,
  input  logic [cmvg_pkg::ScaleW-1:0]      scale_i,
  input  logic signed [cmvg_pkg::QuatW-1:0] quat_x_i,
  input  logic signed [cmvg_pkg::QuatW-1:0] quat_y_i,
  input  logic signed [cmvg_pkg::QuatW-1:0] quat_z_i,
  input  logic signed [cmvg_pkg::QuatW-1:0] quat_w_i,
  input  logic [cmvg_pkg::IdxW-1:0]        index_i,
  input  logic [cmvg_pkg::DimW-1:0]        radius_i,
  input  logic [cmvg_pkg::DimW-1:0]        height_i,
  input  logic [cmvg_pkg::CntW-1:0]        count_i,
  output logic                             job_valid_o,
  input  logic                             job_ready_i,
  output cmvg_pkg::vtx_t                   job_o,
  output logic [KW-1:0]                    job_k_o,
  output logic [cmvg_pkg::RecipW-1:0]      job_recip_o
);
  import cmvg_pkg::*;
  `include "cone_mesh_vertex_generator_top_assert.svh"

  localparam int CmpW = (KW > CntW) ? KW : CntW;

  logic [RecipW-1:0] recip_tab [MAX_SEGMENTS+1];

  for (genvar g = 0; g <= MAX_SEGMENTS; g++) begin : g_recip
    localparam longint unsigned Div = (g < 3) ? 3 : g;
    localparam logic [RecipW-1:0] Recip = RecipW'(((64'd1 << 33) + Div - 1) / Div);
    assign recip_tab[g] = Recip;
  end

  vtx_t              req_q;
  logic [KW-1:0]     idx_q;
  logic [RecipW-1:0] recip_q;
  logic              busy_q, busy_d;
  corner_e           cnt_q, cnt_d;
  logic [CmpW-1:0]   n_full;
  logic [KW-1:0]     n_eff;
  logic              accept, take;

  always_comb begin
    if (CmpW'(count_i) < CmpW'(3)) n_full = CmpW'(3);
    else if (CmpW'(count_i) > CmpW'(MAX_SEGMENTS)) n_full = CmpW'(MAX_SEGMENTS);
    else n_full = CmpW'(count_i);
  end
  assign n_eff = n_full[KW-1:0];

  assign s_ready_o = !busy_q || (job_ready_i && cnt_q == CrnRing0b);
  assign accept    = s_valid_i && s_ready_o;
  assign take      = accept && (CmpW'(index_i) < n_full);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q && job_ready_i) begin
      if (cnt_q == CrnRing0b) busy_d = 1'b0;
      else cnt_d = corner_e'(cnt_q + 3'd1);
    end
    if (take) begin
      busy_d = 1'b1;
      cnt_d  = CrnRing0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= CrnRing0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q.kind   <= KindRing;
      req_q.corner <= CrnRing0;
      req_q.tex_u  <= '0;
      req_q.tex_v  <= '0;
      req_q.base_x <= pos_x_i;
      req_q.base_y <= pos_y_i;
      req_q.base_z <= pos_z_i;
      req_q.quat_x <= quat_x_i;
      req_q.quat_y <= quat_y_i;
      req_q.quat_z <= quat_z_i;
      req_q.quat_w <= quat_w_i;
      req_q.len_r  <= LenW'(radius_i) * LenW'(scale_i);
      req_q.len_h  <= LenW'(height_i) * LenW'(scale_i);
      idx_q        <= KW'(index_i);
      recip_q      <= recip_tab[n_eff];
    end
  end

  always_comb begin
    job_o        = req_q;
    job_o.corner = cnt_q;
    job_o.kind   = KindRing;
    job_o.tex_u  = '0;
    job_o.tex_v  = '0;
    job_k_o      = idx_q;
    unique case (cnt_q)
      CrnRing1, CrnRing1b: job_k_o = idx_q + KW'(1);
      CrnApex: begin
        job_o.kind  = KindApex;
        job_o.tex_v = TexOne;
      end
      CrnCenter: job_o.kind = KindCenter;
      default: ;
    endcase
  end

  assign job_valid_o = busy_q;
  assign job_recip_o = recip_q;

  `CMVG_ASSERT_NXT(a_hold_stall, busy_q && !job_ready_i, busy_q && $stable(cnt_q))
  `CMVG_ASSERT_IMP(a_cnt_range, busy_q, cnt_q <= CrnRing0b)
  `CMVG_ASSERT_NXT(a_take_start, take, busy_q && cnt_q == CrnRing0)
endmodule

// ===== rtl/cmvg_pipe.sv =====
`timescale 1ns / 1ps
module cmvg_pipe #(
  parameter int ANGLE_BITS = 12,
  parameter int KW = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  output logic                             job_ready_o,
  input  cmvg_pkg::vtx_t                   job_i,
  input  logic [KW-1:0]                    job_k_i,
  input  logic [cmvg_pkg::RecipW-1:0]      job_recip_i,
  output logic                             m_valid_o,
  input  logic                             m_ready_i,
  output logic signed [cmvg_pkg::CoordW-1:0] vert_x_o,
  output logic signed [cmvg_pkg::CoordW-1:0] vert_y_o,
  output logic signed [cmvg_pkg::CoordW-1:0] vert_z_o,
  output logic [cmvg_pkg::TexW-1:0]        tex_u_o,
  output logic [cmvg_pkg::TexW-1:0]        tex_v_o,
  output logic [cmvg_pkg::CornerW-1:0]     corner_o,
  output logic                             last_o
);
  import cmvg_pkg::*;

  localparam int ProdW = KW + RecipW;
  localparam int VecW  = 34;
  localparam int LocW  = 48;
  localparam int PW    = 50;
  localparam int TW    = 38;
  localparam int XW    = 54;
  localparam int SumW  = 44;
  localparam logic signed [SumW-1:0] SatHi = SumW'(64'sd2147483647);
  localparam logic signed [SumW-1:0] SatLo = SumW'(-64'sd2147483648);
  localparam logic [15:0] PhaseMask = ~((16'd1 << (16 - ANGLE_BITS)) - 16'd1);

  logic       adv;
  logic [10:1] vld_q;
  vtx_t       c_q [1:9];
  vtx_t       c2_d;

  assign adv         = !vld_q[10] || m_ready_i;
  assign job_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[9:1], job_valid_i};
  end

  // stage 1: reciprocal multiply
  logic [ProdW-1:0] pa_q, pb_q;
  // stage 2: fold to quarter wave
  logic [TexW-1:0] ua, ub;
  logic [TexW:0]   usum;
  logic [15:0]     ph_s, ph_c;
  logic [14:0]     zs_d, zc_d, zs_q, zc_q;
  logic [29:0]     zzs, zzc;
  logic [14:0]     z2s_q, z2c_q;
  logic            neg_s_q, neg_c_q;
  // stages 3 to 5: polynomial
  logic [24:0]     m1s, m1c;
  logic [13:0]     y1s_q, y1c_q;
  logic [28:0]     m2s, m2c;
  logic [14:0]     y2s_q, y2c_q;
  logic [14:0]     zs3_q, zc3_q, zs4_q, zc4_q;
  logic [14:0]     z2s3_q, z2c3_q;
  logic            neg_s3_q, neg_c3_q, neg_s4_q, neg_c4_q;
  logic [29:0]     m3s, m3c;
  logic signed [16:0] sin_q, cos_q;
  // stage 6: local vector
  logic signed [LocW-1:0] lx, lz;
  logic signed [VecW-1:0] vx_d, vy_d, vz_d;
  logic signed [VecW-1:0] v_q [6:9][3];
  // stage 7: cross products
  logic signed [PW-1:0] px1_q, px2_q, py1_q, py2_q, pz1_q, pz2_q;
  // stage 8: t vector
  logic signed [PW:0]   dx, dy, dz;
  logic signed [TW-1:0] tx_q, ty_q, tz_q;
  // stage 9: second products
  logic signed [XW-1:0] wx_q, wy_q, wz_q, cx1_q, cx2_q, cy1_q, cy2_q, cz1_q, cz2_q;
  // stage 10: sum and saturate
  logic signed [XW:0]   ax, ay, az;
  logic signed [XW:0]   bx, by, bz;
  logic signed [SumW-1:0] sx, sy, sz;

  function automatic logic signed [CoordW-1:0] sat(input logic signed [SumW-1:0] v);
    if (v > SatHi) return CoordW'(SatHi);
    if (v < SatLo) return CoordW'(SatLo);
    return v[CoordW-1:0];
  endfunction

  always_comb begin
    ua   = pa_q[33:17];
    ub   = pb_q[33:17];
    usum = {1'b0, ua} + {1'b0, ub};
    c2_d = c_q[1];
    unique case (c_q[1].kind)
      KindApex:   c2_d.tex_u = usum[TexW:1];
      KindCenter: c2_d.tex_u = TexHalf;
      default:    c2_d.tex_u = ua;
    endcase
    ph_s = ua[15:0] & PhaseMask;
    ph_c = ph_s + 16'd16384;
    zs_d = ph_s[14] ? 15'd16384 - {1'b0, ph_s[13:0]} : {1'b0, ph_s[13:0]};
    zc_d = ph_c[14] ? 15'd16384 - {1'b0, ph_c[13:0]} : {1'b0, ph_c[13:0]};
    zzs  = 30'(zs_d) * 30'(zs_d);
    zzc  = 30'(zc_d) * 30'(zc_d);
  end

  always_comb begin
    m1s = 25'(z2s_q) * 25'(SinC);
    m1c = 25'(z2c_q) * 25'(SinC);
    m2s = 29'(z2s3_q) * 29'(y1s_q);
    m2c = 29'(z2c3_q) * 29'(y1c_q);
    m3s = 30'(zs4_q) * 30'(y2s_q);
    m3c = 30'(zc4_q) * 30'(y2c_q);
  end

  always_comb begin
    lx   = cos_q * $signed({1'b0, c_q[5].len_r});
    lz   = sin_q * $signed({1'b0, c_q[5].len_r});
    lx   = lx + LocW'(8192);
    lz   = lz + LocW'(8192);
    vx_d = '0;
    vy_d = '0;
    vz_d = '0;
    unique case (c_q[5].kind)
      KindRing: begin
        vx_d = lx[LocW-1:14];
        vz_d = lz[LocW-1:14];
      end
      KindApex: vy_d = $signed(VecW'(c_q[5].len_h));
      default: ;
    endcase
  end

  always_comb begin
    dx = PW'(px1_q) - PW'(px2_q);
    dy = PW'(py1_q) - PW'(py2_q);
    dz = PW'(pz1_q) - PW'(pz2_q);
    dx = dx + (PW+1)'(4096);
    dy = dy + (PW+1)'(4096);
    dz = dz + (PW+1)'(4096);
  end

  always_comb begin
    ax = (XW+1)'(wx_q) + (XW+1)'(8192);
    ay = (XW+1)'(wy_q) + (XW+1)'(8192);
    az = (XW+1)'(wz_q) + (XW+1)'(8192);
    bx = (XW+1)'(cx1_q) - (XW+1)'(cx2_q) + (XW+1)'(8192);
    by = (XW+1)'(cy1_q) - (XW+1)'(cy2_q) + (XW+1)'(8192);
    bz = (XW+1)'(cz1_q) - (XW+1)'(cz2_q) + (XW+1)'(8192);
    sx = SumW'(c_q[9].base_x) + SumW'(v_q[9][0])
       + SumW'($signed(ax[XW:14])) + SumW'($signed(bx[XW:14]));
    sy = SumW'(c_q[9].base_y) + SumW'(v_q[9][1])
       + SumW'($signed(ay[XW:14])) + SumW'($signed(by[XW:14]));
    sz = SumW'(c_q[9].base_z) + SumW'(v_q[9][2])
       + SumW'($signed(az[XW:14])) + SumW'($signed(bz[XW:14]));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q[1] <= job_i;
      pa_q   <= ProdW'(job_k_i) * ProdW'(job_recip_i);
      pb_q   <= ProdW'(job_k_i + KW'(1)) * ProdW'(job_recip_i);

      c_q[2]  <= c2_d;
      zs_q    <= zs_d;
      zc_q    <= zc_d;
      z2s_q   <= zzs[28:14];
      z2c_q   <= zzc[28:14];
      neg_s_q <= ph_s[15];
      neg_c_q <= ph_c[15];

      c_q[3]   <= c_q[2];
      y1s_q    <= 14'(SinB) - 14'(m1s[24:14]);
      y1c_q    <= 14'(SinB) - 14'(m1c[24:14]);
      zs3_q    <= zs_q;
      zc3_q    <= zc_q;
      z2s3_q   <= z2s_q;
      z2c3_q   <= z2c_q;
      neg_s3_q <= neg_s_q;
      neg_c3_q <= neg_c_q;

      c_q[4]   <= c_q[3];
      y2s_q    <= 15'(SinA) - m2s[28:14];
      y2c_q    <= 15'(SinA) - m2c[28:14];
      zs4_q    <= zs3_q;
      zc4_q    <= zc3_q;
      neg_s4_q <= neg_s3_q;
      neg_c4_q <= neg_c3_q;

      c_q[5] <= c_q[4];
      sin_q  <= neg_s4_q ? -$signed({1'b0, m3s[29:14]}) : $signed({1'b0, m3s[29:14]});
      cos_q  <= neg_c4_q ? -$signed({1'b0, m3c[29:14]}) : $signed({1'b0, m3c[29:14]});

      c_q[6]    <= c_q[5];
      v_q[6][0] <= vx_d;
      v_q[6][1] <= vy_d;
      v_q[6][2] <= vz_d;

      c_q[7] <= c_q[6];
      v_q[7] <= v_q[6];
      px1_q  <= c_q[6].quat_y * v_q[6][2];
      px2_q  <= c_q[6].quat_z * v_q[6][1];
      py1_q  <= c_q[6].quat_z * v_q[6][0];
      py2_q  <= c_q[6].quat_x * v_q[6][2];
      pz1_q  <= c_q[6].quat_x * v_q[6][1];
      pz2_q  <= c_q[6].quat_y * v_q[6][0];

      c_q[8] <= c_q[7];
      v_q[8] <= v_q[7];
      tx_q   <= dx[PW:13];
      ty_q   <= dy[PW:13];
      tz_q   <= dz[PW:13];

      c_q[9] <= c_q[8];
      v_q[9] <= v_q[8];
      wx_q   <= c_q[8].quat_w * tx_q;
      wy_q   <= c_q[8].quat_w * ty_q;
      wz_q   <= c_q[8].quat_w * tz_q;
      cx1_q  <= c_q[8].quat_y * tz_q;
      cx2_q  <= c_q[8].quat_z * ty_q;
      cy1_q  <= c_q[8].quat_z * tx_q;
      cy2_q  <= c_q[8].quat_x * tz_q;
      cz1_q  <= c_q[8].quat_x * ty_q;
      cz2_q  <= c_q[8].quat_y * tx_q;

      vert_x_o <= sat(sx);
      vert_y_o <= sat(sy);
      vert_z_o <= sat(sz);
      tex_u_o  <= c_q[9].tex_u;
      tex_v_o  <= c_q[9].tex_v;
      corner_o <= c_q[9].corner;
      last_o   <= (c_q[9].corner == CrnRing0b);
    end
  end

  assign m_valid_o = vld_q[10];
endmodule

// ===== rtl/cone_mesh_vertex_generator_top.sv =====
`timescale 1ns / 1ps
// Cone segment tessellator. Each accepted request word yields six vertex words, one per
// cycle while the output does not stall; the sequencer issues them into a ten-stage
// arithmetic pipeline and can accept the next request as its last vertex is taken. A
// request whose segment index is not below the effective segment count is dropped in
// its accept cycle and yields no vertices. Registers are written through the APB port;
// the user must write them only while idle, as the block itself does not enforce it.
module cone_mesh_vertex_generator_top #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ANGLE_BITS   = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, uniform_scale, quat_x, quat_y, quat_z, quat_w, segment_index
  input  logic [183:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vert_x, vert_y, vert_z, tex_u, tex_v
  output logic [135:0] m_axis_tdata,
  // corner
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import cmvg_pkg::*;

  localparam int KW = $clog2(MAX_SEGMENTS + 1);

  logic [DimW-1:0]   radius, height;
  logic [CntW-1:0]   count;
  logic              job_valid, job_ready;
  vtx_t              job;
  logic [KW-1:0]     job_k;
  logic [RecipW-1:0] job_recip;
  logic signed [CoordW-1:0] vx, vy, vz;
  logic [TexW-1:0]   tu, tv;

  cmvg_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .radius_o (radius),
    .height_o (height),
    .count_o  (count)
  );

  cmvg_seq #(.MAX_SEGMENTS(MAX_SEGMENTS), .KW(KW)) u_seq (
    .clk_i, .rst_ni,
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .pos_x_i     (s_axis_tdata[31:0]),
    .pos_y_i     (s_axis_tdata[63:32]),
    .pos_z_i     (s_axis_tdata[95:64]),
    .scale_i     (s_axis_tdata[111:96]),
    .quat_x_i    (s_axis_tdata[127:112]),
    .quat_y_i    (s_axis_tdata[143:128]),
    .quat_z_i    (s_axis_tdata[159:144]),
    .quat_w_i    (s_axis_tdata[175:160]),
    .index_i     (s_axis_tdata[181:176]),
    .radius_i    (radius),
    .height_i    (height),
    .count_i     (count),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job),
    .job_k_o     (job_k),
    .job_recip_o (job_recip)
  );

  cmvg_pipe #(.ANGLE_BITS(ANGLE_BITS), .KW(KW)) u_pipe (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .job_k_i     (job_k),
    .job_recip_i (job_recip),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .vert_x_o    (vx),
    .vert_y_o    (vy),
    .vert_z_o    (vz),
    .tex_u_o     (tu),
    .tex_v_o     (tv),
    .corner_o    (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, tv, tu, vz, vy, vx};
endmodule

// ===== tb/cone_mesh_vertex_checker.sv =====
`timescale 1ns / 1ps
module cone_mesh_vertex_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [183:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [135:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           errors_o,
  output int           pending_o
);
  import cmvg_pkg::*;

  localparam int ANGLE_BITS_C = 12;
  localparam int MAX_SEG_C    = 64;

  typedef struct packed {
    logic [31:0]      x;
    logic [31:0]      y;
    logic [31:0]      z;
    logic [TexW-1:0]  u;
    logic [TexW-1:0]  v;
    logic [2:0]       corner;
    logic             last;
  } vertex_t;

  vertex_t          vertex_q[$];
  logic [DimW-1:0]  radius_q8;
  logic [DimW-1:0]  height_q8;
  logic [CntW-1:0]  seg_count;
  int               err_cnt = 0;

  assign pending_o = vertex_q.size();
  assign errors_o  = err_cnt;

  function automatic longint rshift_round(longint x, int k);
    return (x + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint sine_q14(longint phase);
    longint ph, quad, f, z, z2, y, s;
    ph   = phase & 64'hFFFF;
    quad = ph >> 14;
    f    = ph & 64'h3FFF;
    z    = quad[0] ? 16384 - f : f;
    z2   = (z * z) >> 14;
    y    = SinC;
    y    = SinB - ((z2 * y) >> 14);
    y    = SinA - ((z2 * y) >> 14);
    s    = (z * y) >> 14;
    return (quad >= 2) ? -s : s;
  endfunction

  function automatic void rotate_vec(input longint q[4], input longint v[3],
                                     output longint o[3]);
    longint tx, ty, tz;
    tx = rshift_round(q[1] * v[2] - q[2] * v[1], 13);
    ty = rshift_round(q[2] * v[0] - q[0] * v[2], 13);
    tz = rshift_round(q[0] * v[1] - q[1] * v[0], 13);
    o[0] = v[0] + rshift_round(q[3] * tx, 14) + rshift_round(q[1] * tz - q[2] * ty, 14);
    o[1] = v[1] + rshift_round(q[3] * ty, 14) + rshift_round(q[2] * tx - q[0] * tz, 14);
    o[2] = v[2] + rshift_round(q[3] * tz, 14) + rshift_round(q[0] * ty - q[1] * tx, 14);
  endfunction

  function automatic void ring_point(input longint k, input longint n, input longint r,
                                     input longint q[4], input longint b[3],
                                     output longint w[3]);
    longint p, loc[3], rot[3];
    p = ((k << ANGLE_BITS_C) / n) & ((64'sd1 << ANGLE_BITS_C) - 1);
    p = p << (16 - ANGLE_BITS_C);
    loc[0] = rshift_round(sine_q14(p + 16384) * r, 14);
    loc[1] = 0;
    loc[2] = rshift_round(sine_q14(p) * r, 14);
    rotate_vec(q, loc, rot);
    for (int j = 0; j < 3; j++) w[j] = b[j] + rot[j];
  endfunction

  function automatic logic [31:0] clip32(longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic vertex_t make_vertex(longint p[3], longint u, longint v, corner_e c);
    vertex_t e;
    e.x = clip32(p[0]);
    e.y = clip32(p[1]);
    e.z = clip32(p[2]);
    e.u = u[TexW-1:0];
    e.v = v[TexW-1:0];
    e.corner = c;
    e.last = (c == CrnRing0b);
    return e;
  endfunction

  task automatic add_vertex(vertex_t e);
    vertex_q.insert(vertex_q.size(), e);
  endtask

  task automatic predict_segment(logic [183:0] d);
    longint n, i, r, h, u0, u1;
    longint b[3], q[4], p0[3], p1[3], apex[3], loc[3];
    n = seg_count;
    if (n < 3) n = 3;
    if (n > MAX_SEG_C) n = MAX_SEG_C;
    i = d[181:176];
    if (i >= n) return;
    b[0] = $signed(d[31:0]);
    b[1] = $signed(d[63:32]);
    b[2] = $signed(d[95:64]);
    q[0] = $signed(d[127:112]);
    q[1] = $signed(d[143:128]);
    q[2] = $signed(d[159:144]);
    q[3] = $signed(d[175:160]);
    r = longint'(radius_q8) * longint'(d[111:96]);
    h = longint'(height_q8) * longint'(d[111:96]);
    ring_point(i, n, r, q, b, p0);
    ring_point(i + 1, n, r, q, b, p1);
    loc[0] = 0;
    loc[1] = h;
    loc[2] = 0;
    rotate_vec(q, loc, apex);
    for (int j = 0; j < 3; j++) apex[j] += b[j];
    u0 = (i << 16) / n;
    u1 = ((i + 1) << 16) / n;
    add_vertex(make_vertex(p0, u0, 0, CrnRing0));
    add_vertex(make_vertex(p1, u1, 0, CrnRing1));
    add_vertex(make_vertex(apex, (u0 + u1) >> 1, TexOne, CrnApex));
    add_vertex(make_vertex(b, TexHalf, 0, CrnCenter));
    add_vertex(make_vertex(p1, u1, 0, CrnRing1b));
    add_vertex(make_vertex(p0, u0, 0, CrnRing0b));
  endtask

  task automatic compare_vertex();
    vertex_t e, a;
    a.x = m_axis_tdata[31:0];
    a.y = m_axis_tdata[63:32];
    a.z = m_axis_tdata[95:64];
    a.u = m_axis_tdata[112:96];
    a.v = m_axis_tdata[129:113];
    a.corner = m_axis_tuser;
    a.last = m_axis_tlast;
    if (vertex_q.size() == 0) begin
      $display("%0t: unexpected vertex x=%h y=%h z=%h", $time, a.x, a.y, a.z);
      err_cnt++;
      return;
    end
    e = vertex_q.pop_front();
    if (a != e) begin
      $display("%0t: vertex mismatch exp x=%h y=%h z=%h u=%h v=%h c=%0d l=%0d", $time,
               e.x, e.y, e.z, e.u, e.v, e.corner, e.last);
      $display("%0t:                 got x=%h y=%h z=%h u=%h v=%h c=%0d l=%0d", $time,
               a.x, a.y, a.z, a.u, a.v, a.corner, a.last);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q8 <= 14'd256;
      height_q8 <= 14'd256;
      seg_count <= 7'd16;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          RegRadius: radius_q8 <= pwdata[DimW-1:0];
          RegHeight: height_q8 <= pwdata[DimW-1:0];
          RegCount:  seg_count <= pwdata[CntW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_segment(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) compare_vertex();
    end
  end

endmodule

// ===== tb/cone_mesh_vertex_generator_top_test.sv =====
`timescale 1ns / 1ps
module cone_mesh_vertex_generator_top_test;
  import cmvg_pkg::*;

  localparam int IdleLimit = 5000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [183:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int errors;
  int pending;
  int idle_cycles = 0;
  int sink_wait = 0;
  int seg_eff = 16;
  bit steady = 1'b0;

  always #6 clk_i = ~clk_i;

  cone_mesh_vertex_generator_top i_dut (.*);

  cone_mesh_vertex_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      logic rdy;
      rdy = 1'b1;
      if (sink_wait != 0) begin
        sink_wait--;
        rdy = 1'b0;
      end else if (m_axis_tvalid && m_axis_tready && !steady) begin
        sink_wait = $urandom_range(0, 3);
        if (sink_wait != 0) begin
          sink_wait--;
          rdy = 1'b0;
        end
      end
      m_axis_tready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_shape(logic [31:0] radius, logic [31:0] height, logic [31:0] count);
    drain();
    reg_write(RegRadius, radius);
    reg_write(RegHeight, height);
    reg_write(RegCount, count);
    seg_eff = (count[6:0] < 3) ? 3 : (count[6:0] > 64) ? 64 : count[6:0];
  endtask

  task automatic send_segment(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [15:0] scale, logic [15:0] qx, logic [15:0] qy,
                              logic [15:0] qz, logic [15:0] qw, logic [5:0] idx);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, idx, qw, qz, qy, qx, scale, pz, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] quat_part();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic random_segments(int count);
    logic [5:0] idx;
    logic [15:0] scale;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) idx = 6'($urandom_range(0, 63));
      else idx = 6'($urandom_range(0, seg_eff - 1));
      scale = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
      if (k == count / 2) steady = ~steady;
      send_segment($urandom, $urandom, $urandom, scale, quat_part(), quat_part(),
                   quat_part(), quat_part(), idx);
    end
    steady = 1'b0;
  endtask

  task automatic directed_segments();
    send_segment('0, '0, '0, 16'd256, '0, '0, '0, 16'sd16384, 6'd0);
    send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,
                 '0, '0, '0, 16'sd16384, 6'(seg_eff - 1));
    send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF,
                 16'hC000, '0, '0, '0, 6'd1);
    send_segment(32'h0001_0000, 32'hFFFF_0000, '0, '0, '0, 16'sd16384, '0, '0, 6'd0);
    send_segment('0, '0, '0, 16'd512, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
                 6'd2);
    send_segment('0, '0, '0, 16'd512, 16'hC000, 16'hC000, 16'hC000, 16'hC000, 6'd0);
    send_segment(32'h1234_5678, '0, '0, 16'd256, '0, '0, 16'sd11585, 16'sd11585,
                 6'(seg_eff));
    send_segment('0, '0, '0, 16'd256, '0, '0, '0, 16'hC000, 6'd63);
    send_segment(32'h7FFF_0000, 32'h8000_FFFF, '0, 16'hFFFF, 16'sd8192, 16'hE000,
                 16'sd8192, 16'sd8192, 6'd0);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    directed_segments();
    random_segments(25);
    idle_input();
    set_shape(13, 13, 3);
    directed_segments();
    random_segments(20);
    idle_input();
    set_shape(12800, 12800, 64);
    directed_segments();
    random_segments(25);
    idle_input();
    set_shape(16383, 16383, 0);
    random_segments(20);
    idle_input();
    set_shape(0, 0, 127);
    random_segments(18);
    idle_input();
    set_shape(700, 300, 7);
    random_segments(25);
    idle_input();
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
